/* hw/rtl/waveform_envelope_pixel_shader_macros.svh */
// Assertion helpers for the envelope shader.
`ifndef WAVEFORM_ENVELOPE_PIXEL_SHADER_MACROS_SVH
`define WAVEFORM_ENVELOPE_PIXEL_SHADER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WEPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WEPS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

/* hw/rtl/weps_pkg.sv */
package weps_pkg;

  localparam int XW  = 10;        // column, row, entry_index
  localparam int CW  = 11;        // size registers
  localparam int AMPW = 16;
  localparam int COLW = 16;
  localparam int NW  = XW + CW;   // dividend width
  localparam int QW  = CW;        // quotient width
  localparam int IN_DW  = 64;
  localparam int OUT_DW = 64;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    REG_TILE_WIDTH   = 3'd0,
    REG_TILE_HEIGHT  = 3'd1,
    REG_WAVE_LENGTH  = 3'd2,
    REG_BACKGROUND   = 3'd3,
    REG_TRACE_RED    = 3'd4,
    REG_TRACE_GREEN  = 3'd5,
    REG_TRACE_BLUE   = 3'd6,
    REG_ALPHA        = 3'd7
  } cfg_reg_t;

  localparam logic [COLW-1:0] BACKGROUND_RST  = 16'd12329;
  localparam logic [COLW-1:0] TRACE_RED_RST   = 16'd13353;
  localparam logic [COLW-1:0] TRACE_GREEN_RST = 16'd14520;
  localparam logic [COLW-1:0] TRACE_BLUE_RST  = 16'd15319;
  localparam logic [COLW-1:0] ALPHA_RST       = 16'd15360;

  // Item context carried down the index pipeline.
  typedef struct packed {
    logic            kind;
    logic            cond;     // query that can hit at all
    logic [XW-1:0]   row;
    logic            ld_ok;    // load address inside the store
    logic [XW-1:0]   addr;
    logic [AMPW-1:0] dmin;
    logic [AMPW-1:0] dmax;
  } ctx_t;

endpackage

/* hw/rtl/waveform_envelope_pixel_shader.sv */
// Min/max waveform envelope shader. Load transactions (tuser 0) write one
// min/max entry into the waveform store; query transactions (tuser 1) return
// one RGBA half-float pixel with on_trace in tuser, loads return nothing.
// One transaction is accepted per clock while the pipeline is not stalled; a
// query result passes through the 11-stage pipelined column-to-entry divider,
// the registered store read and the row multiply / clamp / compare stages.
// Results leave in acceptance order; a stalled output backs up the pipeline
// one stage at a time, filling bubbles first. Configuration is to be written
// only while no transaction is in flight; the block itself does not enforce this.
module waveform_envelope_pixel_shader #(
  parameter int MAX_ENTRIES  = 1024,
  parameter int MAX_TILE_DIM = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // entry_index[9:0], min_amp[25:10], max_amp[41:26], column[51:42], row[61:52]
  input  logic [weps_pkg::IN_DW-1:0] s_tdata,
  // kind
  input  logic                      s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // red[15:0], green[31:16], blue[47:32], alpha[63:48]
  output logic [weps_pkg::OUT_DW-1:0] m_tdata,
  // on_trace
  output logic                      m_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  weps_pkg::cfg_reg_t        cfg_index,
  input  logic [15:0]               cfg_data
);
  import weps_pkg::*;

  `include "waveform_envelope_pixel_shader_macros.svh"

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [31:0] ENT_MAX  = 32'(MAX_ENTRIES);
  localparam logic [31:0] TILE_MAX = 32'(MAX_TILE_DIM);
  localparam int SM = QW + 1;   // store access stage
  localparam int SP = QW + 2;   // row multiply
  localparam int SC = QW + 3;   // clamp and order
  localparam int NS = QW + 4;   // output register

  // configuration
  logic [CW-1:0]   tile_w, tile_h, wave_len, den, lenm1;
  logic [COLW-1:0] bg_level, trace_red, trace_green, trace_blue, alpha_level;
  logic [CW-1:0]   v11, w_sat, h_sat, len_sat;

  assign cfg_ready = 1'b1;

  always_comb begin
    v11     = cfg_data[CW-1:0];
    w_sat   = ({21'b0, v11} > TILE_MAX) ? TILE_MAX[CW-1:0] : v11;
    h_sat   = ({21'b0, v11} > TILE_MAX) ? TILE_MAX[CW-1:0] : v11;
    len_sat = ({21'b0, v11} > ENT_MAX) ? ENT_MAX[CW-1:0] : v11;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_w      <= '0;
      tile_h      <= '0;
      wave_len    <= '0;
      den         <= CW'(1);
      lenm1       <= '0;
      bg_level    <= BACKGROUND_RST;
      trace_red   <= TRACE_RED_RST;
      trace_green <= TRACE_GREEN_RST;
      trace_blue  <= TRACE_BLUE_RST;
      alpha_level <= ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TILE_WIDTH: begin
          tile_w <= w_sat;
          den    <= (w_sat > CW'(1)) ? w_sat - CW'(1) : CW'(1);
        end
        REG_TILE_HEIGHT: tile_h <= h_sat;
        REG_WAVE_LENGTH: begin
          wave_len <= len_sat;
          lenm1    <= (len_sat != '0) ? len_sat - CW'(1) : '0;
        end
        REG_BACKGROUND:  bg_level    <= cfg_data;
        REG_TRACE_RED:   trace_red   <= cfg_data;
        REG_TRACE_GREEN: trace_green <= cfg_data;
        REG_TRACE_BLUE:  trace_blue  <= cfg_data;
        REG_ALPHA:       alpha_level <= cfg_data;
      endcase
    end
  end

  // pipeline flow control: a stage loads when empty or when its successor loads
  logic [NS:0] vld, ld, vld_in;

  always_comb begin
    ld[NS] = !vld[NS] || m_tready;
    for (int k = NS - 1; k >= 0; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign s_tready = ld[0];

  // stage 0: decode, validity test, dividend x*(len-1)
  logic [XW-1:0] in_col, in_row, in_addr;
  logic [NW-1:0] prod;
  logic          in_cond;

  always_comb begin
    in_addr = s_tdata[9:0];
    in_col  = s_tdata[51:42];
    in_row  = s_tdata[61:52];
    prod    = NW'(in_col) * NW'(lenm1);
    in_cond = (s_tuser == KIND_QUERY) && (wave_len != '0) && (tile_w != '0) &&
              (tile_h != '0) && ({1'b0, in_col} < tile_w) && ({1'b0, in_row} < tile_h);
  end

  // divider pipeline: stage k settles quotient bit QW-k
  ctx_t          ctx_d [0:QW];
  logic [NW-1:0] n_d   [0:QW];
  logic [CW-1:0] r_d   [0:QW];
  logic [QW-1:0] q_d   [0:QW];
  logic [CW:0]   trial [1:QW];
  logic          ge    [1:QW];
  logic [CW-1:0] r_nx  [1:QW];
  logic [QW-1:0] q_nx  [1:QW];

  always_comb begin
    for (int k = 1; k <= QW; k++) begin
      trial[k] = {r_d[k-1], n_d[k-1][QW-k]};
      ge[k]    = trial[k] >= {1'b0, den};
      r_nx[k]  = ge[k] ? CW'(trial[k] - {1'b0, den}) : CW'(trial[k]);
      q_nx[k]  = q_d[k-1];
      q_nx[k][QW-k] = ge[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ctx_d[0].kind  <= s_tuser;
      ctx_d[0].cond  <= in_cond;
      ctx_d[0].row   <= in_row;
      ctx_d[0].ld_ok <= {22'b0, in_addr} < ENT_MAX;
      ctx_d[0].addr  <= in_addr;
      ctx_d[0].dmin  <= s_tdata[25:10];
      ctx_d[0].dmax  <= s_tdata[41:26];
      n_d[0]         <= prod;
      r_d[0]         <= CW'(prod[NW-1:QW]);
      q_d[0]         <= '0;
    end
    for (int k = 1; k <= QW; k++) begin
      if (ld[k]) begin
        ctx_d[k] <= ctx_d[k-1];
        n_d[k]   <= n_d[k-1];
        r_d[k]   <= r_nx[k];
        q_d[k]   <= q_nx[k];
      end
    end
  end

  // waveform store {max, min}: loads write and queries read in order here
  logic [2*AMPW-1:0] wave_mem [0:MAX_ENTRIES-1];
  logic [QW-1:0]     q_clip;
  logic [31:0]       rd_ext, wr_ext;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [2*AMPW-1:0] rd_data;
  logic              mem_we;
  ctx_t              ctx_m;

  always_comb begin
    q_clip  = (q_d[QW] > lenm1) ? lenm1 : q_d[QW];
    rd_ext  = {21'b0, q_clip};
    wr_ext  = {22'b0, ctx_d[QW].addr};
    rd_addr = rd_ext[AW-1:0];
    wr_addr = wr_ext[AW-1:0];
    mem_we  = ld[SM] && vld[SM-1] && (ctx_d[QW].kind == KIND_LOAD) && ctx_d[QW].ld_ok;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wave_mem[wr_addr] <= {ctx_d[QW].dmax, ctx_d[QW].dmin};
    end
    if (ld[SM]) begin
      rd_data <= wave_mem[rd_addr];
      ctx_m   <= ctx_d[QW];
    end
  end

  // row = height*(32768-amp)>>16
  logic [16:0]   scale_top, scale_bot;
  logic [26:0]   mul_top, mul_bot;
  logic [CW-1:0] top_p, bot_p, lo_c, hi_c, top_cl, bot_cl, hm1;
  logic [CW-1:0] lo_w, hi_w;
  logic [XW-1:0] row_p, row_c;
  logic          cond_p, cond_c, hit;

  always_comb begin
    scale_top = 17'h08000 - {rd_data[2*AMPW-1], rd_data[2*AMPW-1:AMPW]};
    scale_bot = 17'h08000 - {rd_data[AMPW-1], rd_data[AMPW-1:0]};
    mul_top   = 27'(tile_h) * 27'(scale_top);
    mul_bot   = 27'(tile_h) * 27'(scale_bot);
    hm1       = tile_h - CW'(1);
    top_cl    = (top_p > hm1) ? hm1 : top_p;
    bot_cl    = (bot_p > hm1) ? hm1 : bot_p;
    // a single-row span grows by one row each way, inside the tile
    lo_w = lo_c;
    hi_w = hi_c;
    if (lo_c == hi_c) begin
      if (lo_c != '0) lo_w = lo_c - CW'(1);
      if (hi_c < hm1) hi_w = hi_c + CW'(1);
    end
    hit = cond_c && ({1'b0, row_c} >= lo_w) && ({1'b0, row_c} <= hi_w);
  end

  always_ff @(posedge clk) begin
    if (ld[SP]) begin
      top_p  <= mul_top[26:16];
      bot_p  <= mul_bot[26:16];
      cond_p <= ctx_m.cond;
      row_p  <= ctx_m.row;
    end
    if (ld[SC]) begin
      lo_c   <= (top_cl > bot_cl) ? bot_cl : top_cl;
      hi_c   <= (top_cl > bot_cl) ? top_cl : bot_cl;
      cond_c <= cond_p;
      row_c  <= row_p;
    end
    if (ld[NS]) begin
      m_tdata <= hit ? {alpha_level, trace_blue, trace_green, trace_red}
                     : {alpha_level, bg_level, bg_level, bg_level};
      m_tuser <= hit;
    end
  end

  // valid bits; loads leave the pipeline after the store stage
  always_comb begin
    vld_in[0] = s_tvalid;
    for (int k = 1; k <= NS; k++) begin
      vld_in[k] = vld[k-1];
    end
    vld_in[SP] = vld[SM] && (ctx_m.kind == KIND_QUERY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k <= NS; k++) begin
        if (ld[k]) vld[k] <= vld_in[k];
      end
    end
  end

  assign m_tvalid = vld[NS];

  `WEPS_ASSERT(a_index_in_range, vld[SM-1] && ctx_d[QW].cond |-> (q_d[QW] <= lenm1), "entry index past waveform length")
  `WEPS_ASSERT(a_trace_color, m_tvalid && m_tuser |-> (m_tdata[15:0] == trace_red), "trace pixel without trace color")
  `WEPS_ASSERT(a_back_color, m_tvalid && !m_tuser |-> (m_tdata[15:0] == bg_level && m_tdata[47:32] == bg_level), "background pixel color mismatch")
  `WEPS_ASSERT_NEXT(a_stage_hold, vld[SC] && !ld[SC], vld[SC], "stalled stage lost its item")

endmodule
